@@ design/vdlc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdlc_pkg
// Shared types, widths and helpers of the L2 / cosine distance engine.
// ----------------------------------------------------------------------------
package vdlc_pkg;

    localparam int MAX_LENGTH   = 1024;
    localparam int ELEMENT_BITS = 16;
    localparam int IN_W         = 16;
    localparam int SIGN_BITS    = (ELEMENT_BITS < IN_W) ? ELEMENT_BITS : IN_W;
    localparam int CNT_W        = $clog2(MAX_LENGTH + 1);

    localparam int DSQ_W  = 43;
    localparam int DOT_W  = 42;
    localparam int NORM_W = 41;
    localparam int DIST_W = 43;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // cosine unit
    localparam int MAG_W       = DOT_W;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int MCNT_W      = $clog2(MAG_W);
    localparam int SRCH_BITS   = 31;
    localparam int SRCH_SHIFT  = 2 * (SRCH_BITS - 1);
    localparam int KCNT_W      = $clog2(SRCH_BITS);
    localparam int WIDE_W      = 145;
    localparam logic [DIST_W-1:0] ONE_Q30 = DIST_W'(64'd1 << 30);
    localparam logic [DIST_W-1:0] TWO_Q30 = DIST_W'(64'd1 << 31);

    typedef struct packed {
        logic signed [IN_W-1:0] elem_a;
        logic signed [IN_W-1:0] elem_b;
        logic                   last_elem;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_out_item;

    // classified transaction between front and back
    typedef struct packed {
        logic                     acc;
        logic                     last;
        logic [2*IN_W-1:0]        dsq;
        logic signed [2*IN_W-1:0] ab;
        logic [2*IN_W-2:0]        aa;
        logic [2*IN_W-2:0]        bb;
    } t_work;

    typedef struct packed {
        logic start;
        logic ack;
    } t_cos_ctl;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] result;
    } t_cos_sts;

    function automatic logic signed [IN_W-1:0] sext(input logic [IN_W-1:0] x);
        logic signed [SIGN_BITS-1:0] t;
        t = x[SIGN_BITS-1:0];
        return IN_W'(t);
    endfunction

endpackage
`default_nettype wire

@@ design/vector_distance_l2_cosine_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_distance_l2_cosine_top
// Squared Euclidean / cosine distance engine over Q1.15 vector pairs.
// ----------------------------------------------------------------------------
// One element pair is taken per transaction and element pairs stream in at
// one per clock while the transaction queue has room. The transaction marked
// last closes the vector and produces one result in units of 2^-30: the sum
// of squared differences (metric 0) or 1 - cos (metric 1, clamped to 0..2).
// In squared Euclidean mode the last pair passes through the transaction
// queue and the sum is loaded into the output register. In cosine mode the
// closing pair starts two shift-add multipliers and a bit-serial root search
// (31 steps), and the next vector's pairs queue behind it in the 4-deep
// transaction queue. Pairs past 1024 are dropped and flag overflow.
// metric_select is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while the block is idle, and the block does not enforce this.
// ----------------------------------------------------------------------------
module vector_distance_l2_cosine_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire vdlc_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output vdlc_pkg::t_out_item     o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata
);
    import vdlc_pkg::*;

    logic                    r_metric;
    logic                    w_push;
    logic                    w_pop;
    logic                    w_full;
    logic                    w_empty;
    t_work                   w_wdata;
    t_work                   w_rdata;
    t_cos_ctl                w_cos_ctl;
    t_cos_sts                w_cos_sts;
    logic [NORM_W-1:0]       w_aa;
    logic [NORM_W-1:0]       w_bb;
    logic signed [DOT_W-1:0] w_dot;

    // metric select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= 1'b0;
        end else if (i_cfg_we) begin
            r_metric <= i_cfg_wdata;
        end
    end

    // front: length check and products
    vdlc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_item   (i_in_item),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_work   (w_wdata)
    );

    // decoupling queue
    vdlc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wdata),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_rdata),
        .o_empty (w_empty)
    );

    // back: accumulation and output register
    vdlc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_metric    (r_metric),
        .i_work      (w_rdata),
        .i_q_empty   (w_empty),
        .o_pop       (w_pop),
        .o_cos_ctl   (w_cos_ctl),
        .i_cos_sts   (w_cos_sts),
        .o_aa        (w_aa),
        .o_bb        (w_bb),
        .o_dot       (w_dot),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // cosine finisher
    vdlc_cos u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cos_ctl),
        .i_aa    (w_aa),
        .i_bb    (w_bb),
        .i_dot   (w_dot),
        .o_sts   (w_cos_sts)
    );

endmodule
`default_nettype wire

@@ design/vdlc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdlc_front
// Accepts element pairs, counts them against the length limit and forms
// the four products.
// ----------------------------------------------------------------------------
module vdlc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire vdlc_pkg::t_in_item i_item,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output vdlc_pkg::t_work        o_work
);
    import vdlc_pkg::*;

    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    logic signed [IN_W-1:0]   w_a;
    logic signed [IN_W-1:0]   w_b;
    logic signed [IN_W:0]     w_d;
    logic signed [2*IN_W+1:0] w_dsq;
    logic signed [2*IN_W-1:0] w_aa;
    logic signed [2*IN_W-1:0] w_bb;
    logic                     w_acc;

    assign w_a   = sext(i_item.elem_a);
    assign w_b   = sext(i_item.elem_b);
    assign w_d   = (IN_W+1)'(w_a) - (IN_W+1)'(w_b);
    assign w_dsq = w_d * w_d;
    assign w_aa  = w_a * w_a;
    assign w_bb  = w_b * w_b;
    assign w_acc = (r_cnt < CNT_W'(MAX_LENGTH));

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_work.acc  = w_acc;
        o_work.last = i_item.last_elem;
        o_work.dsq  = w_dsq[2*IN_W-1:0];
        o_work.ab   = w_a * w_b;
        o_work.aa   = w_aa[2*IN_W-2:0];
        o_work.bb   = w_bb[2*IN_W-2:0];
    end

    always_comb begin
        n_cnt = r_cnt;
        if (o_push) begin
            if (i_item.last_elem) begin
                n_cnt = '0;
            end else if (w_acc) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

@@ design/vdlc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdlc_queue
// Short FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
module vdlc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vdlc_pkg::t_work i_wdata,
    output logic                o_full,
    input  wire logic           i_pop,
    output vdlc_pkg::t_work     o_rdata,
    output logic                o_empty
);
    import vdlc_pkg::*;

    t_work           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ design/vdlc_cos.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdlc_cos
// Exact cosine distance: shift-add products, then bit-by-bit root search.
// ----------------------------------------------------------------------------
module vdlc_cos (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire vdlc_pkg::t_cos_ctl       i_ctl,
    input  wire logic [vdlc_pkg::NORM_W-1:0] i_aa,
    input  wire logic [vdlc_pkg::NORM_W-1:0] i_bb,
    input  wire logic signed [vdlc_pkg::DOT_W-1:0] i_dot,
    output vdlc_pkg::t_cos_sts            o_sts
);
    import vdlc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_SETUP, ST_CAND, ST_TEST, ST_DONE
    } t_state;

    t_state                r_state;
    logic                  r_neg;
    logic [PROD_W-1:0]     r_px;
    logic [MAG_W-1:0]      r_py;
    logic [PROD_W-1:0]     r_mx;
    logic [MAG_W-1:0]      r_my;
    logic [PROD_W-1:0]     r_p;
    logic [PROD_W-1:0]     r_d;
    logic [MCNT_W-1:0]     r_mcnt;
    logic [WIDE_W-1:0]     r_s;
    logic [WIDE_W-1:0]     r_v;
    logic [WIDE_W-1:0]     r_u;
    logic [WIDE_W-1:0]     r_cand;
    logic [SRCH_BITS-1:0]  r_m;
    logic [KCNT_W-1:0]     r_k;
    logic [DIST_W-1:0]     r_res;

    logic [MAG_W-1:0]      w_mag;
    logic [WIDE_W-1:0]     w_rhs;
    logic                  w_ok;
    logic [SRCH_BITS-1:0]  w_m;
    logic [SRCH_BITS:0]    w_n;
    logic [WIDE_W:0]       w_vsum;
    logic [DIST_W-1:0]     w_res;

    assign w_mag  = i_dot[DOT_W-1] ? (~MAG_W'(i_dot) + MAG_W'(1)) : MAG_W'(i_dot);
    assign w_rhs  = WIDE_W'(r_d) << SRCH_SHIFT;
    // negative dot: largest m with m^2*aa*bb <= rhs; else largest with < rhs
    assign w_ok   = r_neg ? (r_cand <= w_rhs) : (r_cand < w_rhs);
    assign w_m    = w_ok ? (r_m | (SRCH_BITS'(1) << r_k)) : r_m;
    assign w_n    = {1'b0, w_m} + (SRCH_BITS+1)'(1);
    assign w_vsum = {1'b0, r_v} + (w_ok ? {r_u, 1'b0} : '0);

    always_comb begin
        if (r_neg) begin
            w_res = w_m[SRCH_BITS-1] ? TWO_Q30 : ONE_Q30 + DIST_W'(w_m);
        end else begin
            w_res = (w_n >= (SRCH_BITS+1)'(ONE_Q30)) ? '0 : ONE_Q30 - DIST_W'(w_n);
        end
    end

    assign o_sts.done   = (r_state == ST_DONE);
    assign o_sts.result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_ctl.start) begin
                        r_neg  <= i_dot[DOT_W-1];
                        r_px   <= PROD_W'(i_aa);
                        r_py   <= MAG_W'(i_bb);
                        r_mx   <= PROD_W'(w_mag);
                        r_my   <= w_mag;
                        r_p    <= '0;
                        r_d    <= '0;
                        r_mcnt <= '0;
                        if (i_aa == '0 || i_bb == '0 || i_dot == '0) begin
                            r_res   <= ONE_Q30;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_p    <= r_p + (r_py[0] ? r_px : '0);
                    r_d    <= r_d + (r_my[0] ? r_mx : '0);
                    r_px   <= r_px << 1;
                    r_mx   <= r_mx << 1;
                    r_py   <= r_py >> 1;
                    r_my   <= r_my >> 1;
                    r_mcnt <= r_mcnt + MCNT_W'(1);
                    if (r_mcnt == MCNT_W'(MAG_W - 1)) begin
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_s     <= '0;
                    r_v     <= '0;
                    r_u     <= WIDE_W'(r_p) << SRCH_SHIFT;
                    r_m     <= '0;
                    r_k     <= KCNT_W'(SRCH_BITS - 1);
                    r_state <= ST_CAND;
                end
                ST_CAND: begin
                    r_cand  <= r_s + r_v + r_u;
                    r_state <= ST_TEST;
                end
                ST_TEST: begin
                    if (w_ok) begin
                        r_s <= r_cand;
                    end
                    r_m <= w_m;
                    r_v <= w_vsum[WIDE_W:1];
                    r_u <= r_u >> 2;
                    if (r_k == '0) begin
                        r_res   <= w_res;
                        r_state <= ST_DONE;
                    end else begin
                        r_k     <= r_k - KCNT_W'(1);
                        r_state <= ST_CAND;
                    end
                end
                ST_DONE: begin
                    if (i_ctl.ack) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ design/vdlc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdlc_back
// Saturating accumulators, result selection and the output register.
// ----------------------------------------------------------------------------
module vdlc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_metric,
    input  wire vdlc_pkg::t_work  i_work,
    input  wire logic             i_q_empty,
    output logic                  o_pop,
    output vdlc_pkg::t_cos_ctl    o_cos_ctl,
    input  wire vdlc_pkg::t_cos_sts i_cos_sts,
    output logic [vdlc_pkg::NORM_W-1:0] o_aa,
    output logic [vdlc_pkg::NORM_W-1:0] o_bb,
    output logic signed [vdlc_pkg::DOT_W-1:0] o_dot,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output vdlc_pkg::t_out_item   o_out_item
);
    import vdlc_pkg::*;

    typedef enum logic {ST_ACC, ST_COS} t_state;

    t_state                    r_state;
    logic [DSQ_W-1:0]          r_dsq;
    logic signed [DOT_W-1:0]   r_dot;
    logic [NORM_W-1:0]         r_na;
    logic [NORM_W-1:0]         r_nb;
    logic                      r_ovf;
    logic                      r_ovf_hold;
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    logic [DSQ_W-1:0]          n_dsq;
    logic signed [DOT_W-1:0]   n_dot;
    logic [NORM_W-1:0]         n_na;
    logic [NORM_W-1:0]         n_nb;
    logic                      n_ovf;
    logic [DSQ_W:0]            w_sdsq;
    logic signed [DOT_W:0]     w_sdot;
    logic [NORM_W:0]           w_sna;
    logic [NORM_W:0]           w_snb;
    logic                      w_out_free;
    logic                      w_last;
    logic                      w_load;

    assign w_sdsq = {1'b0, r_dsq} + (DSQ_W+1)'(i_work.dsq);
    assign w_sdot = (DOT_W+1)'(r_dot) + (DOT_W+1)'(i_work.ab);
    assign w_sna  = {1'b0, r_na} + (NORM_W+1)'(i_work.aa);
    assign w_snb  = {1'b0, r_nb} + (NORM_W+1)'(i_work.bb);

    always_comb begin
        n_dsq = r_dsq;
        n_dot = r_dot;
        n_na  = r_na;
        n_nb  = r_nb;
        n_ovf = r_ovf;
        if (i_work.acc) begin
            n_dsq = w_sdsq[DSQ_W] ? '1 : w_sdsq[DSQ_W-1:0];
            n_na  = w_sna[NORM_W] ? '1 : w_sna[NORM_W-1:0];
            n_nb  = w_snb[NORM_W] ? '1 : w_snb[NORM_W-1:0];
            if (w_sdot[DOT_W] != w_sdot[DOT_W-1]) begin
                n_dot = w_sdot[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                      : {1'b0, {(DOT_W-1){1'b1}}};
            end else begin
                n_dot = w_sdot[DOT_W-1:0];
            end
        end else begin
            n_ovf = 1'b1;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_last     = i_work.last;
    assign o_pop      = (r_state == ST_ACC) && !i_q_empty
                        && (!w_last || i_metric || w_out_free);

    assign o_cos_ctl.start = o_pop && w_last && i_metric;
    assign o_cos_ctl.ack   = (r_state == ST_COS) && i_cos_sts.done && w_out_free;
    assign o_aa  = n_na;
    assign o_bb  = n_nb;
    assign o_dot = n_dot;

    // output register is reloaded this cycle
    assign w_load = ((r_state == ST_ACC) && o_pop && w_last && !i_metric)
                    || o_cos_ctl.ack;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACC;
            r_dsq       <= '0;
            r_dot       <= '0;
            r_na        <= '0;
            r_nb        <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_ACC: begin
                    if (o_pop) begin
                        if (w_last) begin
                            r_dsq <= '0;
                            r_dot <= '0;
                            r_na  <= '0;
                            r_nb  <= '0;
                            r_ovf <= 1'b0;
                            if (i_metric) begin
                                r_ovf_hold <= n_ovf;
                                r_state    <= ST_COS;
                            end else begin
                                r_out_item.distance <= DIST_W'(n_dsq);
                                r_out_item.overflow <= n_ovf;
                                r_out_valid         <= 1'b1;
                            end
                        end else begin
                            r_dsq <= n_dsq;
                            r_dot <= n_dot;
                            r_na  <= n_na;
                            r_nb  <= n_nb;
                            r_ovf <= n_ovf;
                        end
                    end
                end
                ST_COS: begin
                    if (o_cos_ctl.ack) begin
                        r_out_item.distance <= i_cos_sts.result;
                        r_out_item.overflow <= r_ovf_hold;
                        r_out_valid         <= 1'b1;
                        r_state             <= ST_ACC;
                    end
                end
                default: r_state <= ST_ACC;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ design/vdlc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdlc_checker
// Port-level checks of the distance engine, bound to the top level.
// ----------------------------------------------------------------------------
module vdlc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire vdlc_pkg::t_in_item i_in_item,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire vdlc_pkg::t_out_item o_out_item,
    input wire logic               i_cfg_we
);
    import vdlc_pkg::*;

    logic [7:0] r_pending;
    logic       w_in_last;
    logic       w_out_acc;

    assign w_in_last = i_in_valid && o_in_ready && i_in_item.last_elem;
    assign w_out_acc = o_out_valid && i_out_ready;

    // closed vectors whose result is not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_last && !w_out_acc) begin
            r_pending <= r_pending + 8'd1;
        end else if (!w_in_last && w_out_acc) begin
            r_pending <= r_pending - 8'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 8'd0)
        else $error("result without a closed vector");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_out_item.distance[DIST_W-1])
        else $error("distance out of range");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> r_pending == 8'd0 && !i_in_valid)
        else $error("metric written while busy");

endmodule

bind vector_distance_l2_cosine_top vdlc_checker u_vdlc_checker (.*);
`default_nettype wire

@@ tb/sv/vector_distance_l2_cosine_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_distance_l2_cosine_top_tb
// Self-checking bench for the L2 / cosine distance engine.
// ----------------------------------------------------------------------------
// Streams element pairs through the input handshake, works out each expected
// distance alongside the block (exact integer search for the cosine case),
// and compares every result transaction with the oldest expected one.
// Directed vectors cover field extremes, zero norms, aligned and opposed
// vectors and over-length vectors; random vectors follow in both metrics.
// ----------------------------------------------------------------------------
module vector_distance_l2_cosine_top_tb;
    import vdlc_pkg::*;

    localparam int  CYCLE_LIMIT = 2_000_000;
    // allow margin for an outstanding cosine result before config writes
    localparam int  DRAIN_CYCLES = 200;
    localparam logic METRIC_L2  = 1'b0;
    localparam logic METRIC_COS = 1'b1;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;
    logic      i_cfg_we;
    logic      i_cfg_wdata;

    vector_distance_l2_cosine_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ---- bench state --------------------------------------------------------
    t_out_item  dist_expected[$];
    int         error_count = 0;
    int         cycle_count = 0;
    bit         send_gaps   = 0;   // random idling on the input side
    bit         sink_stalls = 0;   // random back-pressure on the result side

    // shadow of the block's accumulators and register
    logic               metric_shadow;
    logic [DSQ_W-1:0]   dsq_acc;
    logic signed [DOT_W-1:0] dot_acc;
    logic [NORM_W-1:0]  norm_a_acc;
    logic [NORM_W-1:0]  norm_b_acc;
    int                 pair_count;
    logic               too_long;

    // ---- clock --------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---- cosine distance: exact floor of 2^30 * (1 - dot / sqrt(aa*bb)) ---
    function automatic logic [DIST_W-1:0] expected_cos(
        input logic signed [DOT_W-1:0] dot,
        input logic [NORM_W-1:0] na,
        input logic [NORM_W-1:0] nb);
        logic [191:0] rhs, prod, lhs;
        logic [63:0]  mag;
        logic [31:0]  lo, hi, mid;
        if (na == 0 || nb == 0)
            return ONE_Q30;
        mag  = (dot < 0) ? 64'(-dot) : 64'(dot);
        rhs  = (192'(mag) * 192'(mag)) << 60;
        prod = 192'(na) * 192'(nb);
        lo   = 0;
        hi   = 32'(1 << 30) + 1;
        if (dot >= 0) begin
            // smallest n whose n^2*aa*bb reaches dot^2 * 2^60
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                lhs = 192'(mid) * 192'(mid) * prod;
                if (lhs >= rhs) hi = mid;
                else            lo = mid + 1;
            end
            return (lo >= (1 << 30)) ? '0 : ONE_Q30 - DIST_W'(lo);
        end
        // largest m whose m^2*aa*bb stays within dot^2 * 2^60
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = 192'(mid) * 192'(mid) * prod;
            if (lhs <= rhs) lo = mid;
            else            hi = mid - 1;
        end
        return (lo >= (1 << 30)) ? TWO_Q30 : ONE_Q30 + DIST_W'(lo);
    endfunction

    task automatic clear_shadow();
        dsq_acc    = '0;
        dot_acc    = '0;
        norm_a_acc = '0;
        norm_b_acc = '0;
        pair_count = 0;
        too_long   = 1'b0;
    endtask

    // fold one accepted pair into the shadow; queue a distance on the last one
    task automatic accumulate_pair(input t_in_item it);
        longint a, b, d, s;
        t_out_item res;
        a = longint'(it.elem_a);
        b = longint'(it.elem_b);
        if (pair_count < MAX_LENGTH) begin
            d = a - b;
            pair_count++;
            dsq_acc    = (longint'(dsq_acc) + d * d > (64'd1 << DSQ_W) - 1)
                       ? '1 : DSQ_W'(longint'(dsq_acc) + d * d);
            norm_a_acc = (longint'(norm_a_acc) + a * a > (64'd1 << NORM_W) - 1)
                       ? '1 : NORM_W'(longint'(norm_a_acc) + a * a);
            norm_b_acc = (longint'(norm_b_acc) + b * b > (64'd1 << NORM_W) - 1)
                       ? '1 : NORM_W'(longint'(norm_b_acc) + b * b);
            s = longint'(dot_acc) + a * b;
            if (s >  (longint'(1) << 41) - 1) s =  (longint'(1) << 41) - 1;
            if (s < -(longint'(1) << 41))     s = -(longint'(1) << 41);
            dot_acc = DOT_W'(s);
        end else begin
            too_long = 1'b1;
        end
        if (it.last_elem) begin
            res.distance = (metric_shadow == METRIC_COS)
                         ? expected_cos(dot_acc, norm_a_acc, norm_b_acc) : dsq_acc;
            res.overflow = too_long;
            dist_expected.push_back(res);
            clear_shadow();
        end
    endtask

    // ---- monitor: input acceptance, result checking, watchdog -------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                accumulate_pair(i_in_item);
            if (o_out_valid && i_out_ready) begin
                if (dist_expected.size() == 0) begin
                    $error("unexpected result transaction: distance %0d overflow %0d",
                           o_out_item.distance, o_out_item.overflow);
                    error_count++;
                end else begin
                    if (o_out_item.distance !== dist_expected[0].distance) begin
                        $error("distance: expected %0d, actual %0d",
                               dist_expected[0].distance, o_out_item.distance);
                        error_count++;
                    end
                    if (o_out_item.overflow !== dist_expected[0].overflow) begin
                        $error("overflow: expected %0d, actual %0d",
                               dist_expected[0].overflow, o_out_item.overflow);
                        error_count++;
                    end
                    void'(dist_expected.pop_front());
                end
            end
        end
    end

    // ---- result side back-pressure -----------------------------------------
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready = (stall_left == 0);
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                stall_left  = $urandom_range(1, 16);
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // ---- stimulus helpers ---------------------------------------------------
    // one pair transaction; returns at the falling edge after acceptance
    task automatic send_pair(input logic signed [IN_W-1:0] a,
                             input logic signed [IN_W-1:0] b, input logic last);
        if (send_gaps && $urandom_range(0, 6) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid          = 1'b1;
        i_in_item.elem_a    = a;
        i_in_item.elem_b    = b;
        i_in_item.last_elem = last;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (dist_expected.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_metric(input logic m);
        wait_drained();
        i_cfg_we      = 1'b1;
        i_cfg_wdata   = m;
        metric_shadow = m;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // field value biased towards the extremes
    function automatic logic signed [IN_W-1:0] pick_elem();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return IN_W'($urandom_range(0, 15)) - 16'sd8;
            default: return IN_W'($urandom);
        endcase
    endfunction

    // random vector pairs; b is sometimes a scaled / negated / nudged copy of a
    task automatic send_random_vectors(input int n_items);
        int sent, len, style, i;
        logic signed [IN_W-1:0] a, b;
        sent = 0;
        while (sent < n_items) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                : $urandom_range(1, 16);
            style = $urandom_range(0, 5);
            for (i = 0; i < len; i++) begin
                a = pick_elem();
                case (style)
                    0:       b = a;
                    1:       b = (a == 16'sh8000) ? 16'sh7FFF : -a;
                    2:       b = a >>> 1;
                    3:       b = a + IN_W'($urandom_range(0, 63)) - 16'sd32;
                    default: b = pick_elem();
                endcase
                send_pair(a, b, i == len - 1);
            end
            sent += len;
        end
    endtask

    // ---- tests ---------------------------------------------------------------
    task automatic test_l2_extremes();
        set_metric(METRIC_L2);
        send_pair(16'sh7FFF, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh7FFF, 1'b0);
        send_pair(16'sh0000, 16'sh0000, 1'b0);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);   // single-pair vector
        send_pair(16'sh0001, 16'shFFFF, 1'b1);
    endtask

    task automatic test_cosine_cases();
        set_metric(METRIC_COS);
        send_pair(16'sh0000, 16'sh1234, 1'b0);   // a has zero norm
        send_pair(16'sh0000, 16'sh8000, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b1);   // both zero
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);   // aligned: distance 0
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7FFF, 1'b0);   // opposed: close to 2.0
        send_pair(16'sh7FFF, 16'sh8000, 1'b1);
        send_pair(16'sh4000, 16'sh0000, 1'b0);   // orthogonal: 1.0
        send_pair(16'sh0000, 16'sh4000, 1'b1);
        send_pair(16'sh0001, 16'shFFFF, 1'b1);
        send_pair(16'sh0003, 16'sh0005, 1'b0);
        send_pair(16'shFFFC, 16'sh0007, 1'b1);
    endtask

    // pairs past MAX_LENGTH are dropped and flag overflow
    task automatic test_length_overflow(input logic m);
        int i;
        set_metric(m);
        for (i = 0; i < MAX_LENGTH + 5; i++)
            send_pair(pick_elem(), pick_elem(), i == MAX_LENGTH + 4);
        send_pair(16'sh0100, 16'sh0200, 1'b1);   // flag must clear afterwards
    endtask

    task automatic test_random_l2();
        set_metric(METRIC_L2);
        send_gaps   = 1;
        sink_stalls = 1;
        send_random_vectors(300);
    endtask

    task automatic test_random_cosine();
        set_metric(METRIC_COS);
        send_gaps   = 1;
        sink_stalls = 1;
        send_random_vectors(250);
    endtask

    // closing stretch at full rate, no idling on either side
    task automatic test_full_rate();
        send_gaps   = 0;
        sink_stalls = 0;
        set_metric(METRIC_L2);
        send_random_vectors(150);
        set_metric(METRIC_COS);
        send_random_vectors(100);
    endtask

    // ---- main sequence -------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        metric_shadow = METRIC_L2;
        clear_shadow();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // first vector runs on the reset value of the register
        send_pair(16'sh1000, 16'sh0800, 1'b1);
        test_l2_extremes();
        test_cosine_cases();
        test_length_overflow(METRIC_COS);
        test_random_l2();
        test_random_cosine();
        test_full_rate();

        wait_drained();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
